// ===== hdl/chtlp_pkg.sv =====
//------------------------------------------------------------------------------
// chtlp_pkg
// shared types and constants for the coordinate hash table
//------------------------------------------------------------------------------
`default_nettype none
package chtlp_pkg;
	localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_NEW      = 3'd2,
		ST_REPLACED = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} opcode_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] key_x;
		logic [31:0] key_y;
		logic [31:0] key_z;
		logic [31:0] insert_handle;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_handle;
		logic [9:0]  slot_index;
		logic [10:0] occupancy;
	} out_beat_t;

	// multiply by 33 then xor in a coordinate
	function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [31:0] c);
		logic [63:0] m;
		m = (h << 5) + h;
		return m ^ {32'd0, c};
	endfunction

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_DONE,
		BK_CLEAR
	} back_state_t;
endpackage
`default_nettype wire

// ===== hdl/coord_hash_table_linear_probe.sv =====
// the front hashes the key; the back reads and then checks each probed slot
// and registers the result, and takes a new beat only when done with the last
// the front hashes and queues up to two beats while the back probes
// reset clears the occupancy count and starts a pass that clears every slot of the
// slot memory; beats wait in the front until the pass ends
//------------------------------------------------------------------------------
// coord_hash_table_linear_probe
// open-addressing table keyed by three coordinates with linear probing
//------------------------------------------------------------------------------
`default_nettype none
module coord_hash_table_linear_probe #(
	parameter int TABLE_SLOTS = 1024,
	parameter int HANDLE_BITS = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire chtlp_pkg::in_beat_t  in_beat,
	output logic                      out_valid,
	input  wire                       out_stall,
	output chtlp_pkg::out_beat_t      out_beat
);
	localparam int IDX_BITS = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	logic                 q_valid, q_pop;
	chtlp_pkg::in_beat_t  q_beat;
	logic [IDX_BITS-1:0]  q_home;

	chtlp_front #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_BITS(IDX_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_beat,
		.q_valid, .q_pop, .q_beat, .q_home
	);

	chtlp_back #(
		.TABLE_SLOTS(TABLE_SLOTS), .HANDLE_BITS(HANDLE_BITS), .IDX_BITS(IDX_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_beat, .q_home,
		.out_valid, .out_stall, .out_beat
	);
endmodule
`default_nettype wire

// ===== hdl/chtlp_front.sv =====
//------------------------------------------------------------------------------
// chtlp_front
// accepts beats, hashes the key over three stages and queues the home slot
//------------------------------------------------------------------------------
`default_nettype none
module chtlp_front #(
	parameter int TABLE_SLOTS = 1024,
	parameter int IDX_BITS    = 10
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire chtlp_pkg::in_beat_t in_beat,
	output logic                     q_valid,
	input  wire                      q_pop,
	output chtlp_pkg::in_beat_t      q_beat,
	output logic [IDX_BITS-1:0]      q_home
);
	logic                    v_s1, v_s2, v_s3;
	chtlp_pkg::in_beat_t     b_s1, b_s2, b_s3;
	logic [63:0]             h_s1, h_s2, h_s3;
	logic                    adv;

	// two-entry queue
	chtlp_pkg::in_beat_t     qb_q [2];
	logic [IDX_BITS-1:0]     qh_q [2];
	logic                    wp_q, rp_q;
	logic [1:0]              cnt_q;
	logic                    push;

	// pipeline advances only when the queue can take the beat leaving the last stage
	assign adv = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !v_s3) || (q_pop && !v_s3)
		|| (q_pop && cnt_q == 2'd1);
	assign in_stall = !adv;
	assign push = adv && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1 <= in_beat;
			h_s1 <= chtlp_pkg::hash_step(chtlp_pkg::HASH_BASIS, in_beat.key_x);
			b_s2 <= b_s1;
			h_s2 <= chtlp_pkg::hash_step(h_s1, b_s1.key_y);
			b_s3 <= b_s2;
			h_s3 <= chtlp_pkg::hash_step(h_s2, b_s2.key_z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop && q_valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qb_q[wp_q] <= b_s3;
			qh_q[wp_q] <= h_s3[IDX_BITS-1:0] & IDX_BITS'(TABLE_SLOTS - 1);
		end
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_beat  = qb_q[rp_q];
	assign q_home  = qh_q[rp_q];
endmodule
`default_nettype wire

// ===== hdl/chtlp_back.sv =====
//------------------------------------------------------------------------------
// chtlp_back
// clears the slot memory after reset, then probes it one slot at a time, reading and then checking each slot,
// and builds the result beat
//------------------------------------------------------------------------------
`default_nettype none
module chtlp_back #(
	parameter int TABLE_SLOTS = 1024,
	parameter int HANDLE_BITS = 32,
	parameter int IDX_BITS    = 10
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      q_valid,
	output logic                     q_pop,
	input  wire chtlp_pkg::in_beat_t q_beat,
	input  wire [IDX_BITS-1:0]       q_home,
	output logic                     out_valid,
	input  wire                      out_stall,
	output chtlp_pkg::out_beat_t     out_beat
);
	// valid bit on top, then the three coordinates, then the handle
	localparam int ENT_BITS = 97 + HANDLE_BITS;

	logic [ENT_BITS-1:0]     mem [TABLE_SLOTS];
	logic [ENT_BITS-1:0]     rd_q;
	logic [IDX_BITS-1:0]     clr_q;
	logic [IDX_BITS:0]       used_q;
	logic [IDX_BITS:0]       n_q;
	logic [IDX_BITS-1:0]     idx_q;
	chtlp_pkg::in_beat_t     cur_q;
	chtlp_pkg::back_state_t  st_q, st_d;
	logic                    ov_q;
	chtlp_pkg::out_beat_t    ob_q;
	logic                    match, empty, pass_end, wr, fin;
	logic [HANDLE_BITS-1:0]  hnd;
	logic [IDX_BITS-1:0]     nidx;

	assign hnd   = HANDLE_BITS'(cur_q.insert_handle);
	assign match = rd_q[ENT_BITS-2 -: 96] == {cur_q.key_x, cur_q.key_y, cur_q.key_z};
	assign empty = !rd_q[ENT_BITS-1];
	assign pass_end = n_q == (IDX_BITS+1)'(TABLE_SLOTS - 1);
	assign nidx  = (idx_q == IDX_BITS'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign fin   = (st_q == chtlp_pkg::BK_CHECK) && (empty || match || pass_end);
	assign wr    = fin && cur_q.opcode == chtlp_pkg::OP_INSERT && (empty || match);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			chtlp_pkg::BK_CLEAR: if (clr_q == IDX_BITS'(TABLE_SLOTS - 1)) st_d = chtlp_pkg::BK_IDLE;
			chtlp_pkg::BK_IDLE:  if (q_valid) st_d = chtlp_pkg::BK_READ;
			chtlp_pkg::BK_READ:  st_d = chtlp_pkg::BK_CHECK;
			chtlp_pkg::BK_CHECK: st_d = fin ? chtlp_pkg::BK_DONE : chtlp_pkg::BK_READ;
			chtlp_pkg::BK_DONE:  if (!ov_q || !out_stall) st_d = chtlp_pkg::BK_IDLE;
			default:             st_d = chtlp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = st_q == chtlp_pkg::BK_IDLE && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= chtlp_pkg::BK_CLEAR;
			clr_q  <= '0;
			used_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == chtlp_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (wr && empty) used_q <= used_q + 1'b1;
			if (st_q == chtlp_pkg::BK_DONE && (!ov_q || !out_stall)) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_beat;
			idx_q <= q_home;
			n_q   <= '0;
		end else if (st_q == chtlp_pkg::BK_CHECK && !fin) begin
			idx_q <= nidx;
			n_q   <= n_q + 1'b1;
		end
		if (st_q == chtlp_pkg::BK_READ) rd_q <= mem[idx_q];
		if (st_q == chtlp_pkg::BK_CLEAR) mem[clr_q] <= '0;
		else if (wr) mem[idx_q] <= {1'b1, cur_q.key_x, cur_q.key_y, cur_q.key_z, hnd};
		if (fin) begin
			ob_q.found_handle <= '0;
			ob_q.slot_index   <= '0;
			ob_q.occupancy    <= 11'((wr && empty) ? used_q + 1'b1 : used_q);
			if (empty && cur_q.opcode == chtlp_pkg::OP_INSERT) begin
				ob_q.status     <= chtlp_pkg::ST_NEW;
				ob_q.slot_index <= 10'(idx_q);
			end else if (empty) begin
				ob_q.status <= chtlp_pkg::ST_MISS;
			end else if (match && cur_q.opcode == chtlp_pkg::OP_INSERT) begin
				ob_q.status     <= chtlp_pkg::ST_REPLACED;
				ob_q.slot_index <= 10'(idx_q);
			end else if (match) begin
				ob_q.status       <= chtlp_pkg::ST_HIT;
				ob_q.slot_index   <= 10'(idx_q);
				ob_q.found_handle <= 32'(rd_q[HANDLE_BITS-1:0]);
			end else if (cur_q.opcode == chtlp_pkg::OP_INSERT) begin
				ob_q.status <= chtlp_pkg::ST_FULL;
			end else begin
				ob_q.status <= chtlp_pkg::ST_MISS;
			end
		end
		if (st_q == chtlp_pkg::BK_DONE && (!ov_q || !out_stall)) out_beat <= ob_q;
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire
